FILE: hdl/scpg_pkg.sv
// Shared types, constants and tables for the sphere/circle point generator.
`timescale 1ns / 1ps
package scpg_pkg;

  localparam int IDX_W   = 16;
  localparam int CRD_W   = 20;
  localparam int RAD_W   = 19;
  localparam int DIV_W   = IDX_W + 17;
  localparam int DIV_N   = DIV_W;
  localparam int ROT_N   = 17;
  localparam int CFG_W   = 3 * CRD_W;
  localparam int CFG_A_W = 3;
  localparam int OUT_W   = 80;

  localparam logic [31:0] GOLDEN_TURN = 32'h61C8_8647;
  localparam logic signed [19:0] CORDIC_START = 20'sd39796;

  // Configuration register indexes.
  typedef enum logic [CFG_A_W-1:0] {
    REG_MODE    = 3'd0,
    REG_COUNT   = 3'd1,
    REG_CENTRE  = 3'd2,
    REG_MAJOR   = 3'd3,
    REG_MINOR   = 3'd4,
    REG_BOX_LO  = 3'd5,
    REG_BOX_HI  = 3'd6
  } reg_idx_t;

  // Payload that travels down the divider and rotation chains.
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [31:0]       turn;
    logic [IDX_W-1:0]  rem;
    logic [DIV_W-1:0]  dq;
    logic signed [17:0] zq;
    logic [32:0]       sd;
    logic [33:0]       sres;
    logic signed [19:0] cx;
    logic signed [19:0] cy;
    logic signed [33:0] cz;
    logic              flip;
  } pipe_t;

  // Arctangent of 2^-k as a fraction of a full turn in Q0.32.
  function automatic logic [31:0] atan_turn(input logic [3:0] k);
    logic [31:0] a;
    unique case (k)
      4'd0:  a = 32'h2000_0000;
      4'd1:  a = 32'h12E4_051E;
      4'd2:  a = 32'h09FB_385B;
      4'd3:  a = 32'h0511_11D4;
      4'd4:  a = 32'h028B_0D43;
      4'd5:  a = 32'h0145_D7E1;
      4'd6:  a = 32'h00A2_F61E;
      4'd7:  a = 32'h0051_7C55;
      4'd8:  a = 32'h0028_BE53;
      4'd9:  a = 32'h0014_5F2F;
      4'd10: a = 32'h000A_2F98;
      4'd11: a = 32'h0005_17CC;
      4'd12: a = 32'h0002_8BE6;
      4'd13: a = 32'h0001_45F3;
      4'd14: a = 32'h0000_A2FA;
      default: a = 32'h0000_517D;
    endcase
    return a;
  endfunction

endpackage

FILE: hdl/scpg_div_cell.sv
// One restoring-division cell: produces one quotient bit per stage.
`timescale 1ns / 1ps
module scpg_div_cell (
  input  logic                        clk,
  input  logic                        en,
  input  logic [scpg_pkg::IDX_W-1:0]  divisor,
  input  scpg_pkg::pipe_t             d_in,
  output scpg_pkg::pipe_t             d_out
);

  logic [scpg_pkg::IDX_W:0] trial;
  logic                     ge;
  scpg_pkg::pipe_t          item_nxt;
  scpg_pkg::pipe_t          item_r;

  // Shift the next dividend bit into the remainder and try to subtract.
  always_comb begin
    trial    = {d_in.rem, d_in.dq[scpg_pkg::DIV_W-1]};
    ge       = trial >= {1'b0, divisor};
    item_nxt = d_in;
    item_nxt.rem = ge ? scpg_pkg::IDX_W'(trial - {1'b0, divisor})
                      : trial[scpg_pkg::IDX_W-1:0];
    item_nxt.dq  = {d_in.dq[scpg_pkg::DIV_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign d_out = item_r;

endmodule

FILE: hdl/scpg_rot_cell.sv
// One square-root step and, except at the last step, one CORDIC rotation, registered per stage.
`timescale 1ns / 1ps
module scpg_rot_cell (
  input  logic            clk,
  input  logic            en,
  input  logic [4:0]      step,
  input  scpg_pkg::pipe_t d_in,
  output scpg_pkg::pipe_t d_out
);

  logic [33:0]        bitv;
  logic [33:0]        trial;
  logic signed [19:0] dx;
  logic signed [19:0] dy;
  logic signed [33:0] ang;
  scpg_pkg::pipe_t    item_nxt;
  scpg_pkg::pipe_t    item_r;

  always_comb begin
    bitv  = 34'd1 << (6'd32 - {step, 1'b0});
    trial = d_in.sres + bitv;
    dx    = d_in.cy >>> step[3:0];
    dy    = d_in.cx >>> step[3:0];
    ang   = $signed({2'b00, scpg_pkg::atan_turn(step[3:0])});
    item_nxt = d_in;
    // Digit-by-digit floor square root.
    if ({1'b0, d_in.sd} >= trial) begin
      item_nxt.sd   = 33'(d_in.sd - trial[32:0]);
      item_nxt.sres = (d_in.sres >> 1) + bitv;
    end else begin
      item_nxt.sres = d_in.sres >> 1;
    end
    // Rotation toward zero residual angle; the last stage has no rotation.
    if (!step[4]) begin
      if (!d_in.cz[33]) begin
        item_nxt.cx = d_in.cx - dx;
        item_nxt.cy = d_in.cy + dy;
        item_nxt.cz = d_in.cz - ang;
      end else begin
        item_nxt.cx = d_in.cx + dx;
        item_nxt.cy = d_in.cy - dy;
        item_nxt.cz = d_in.cz + ang;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

  assign d_out = item_r;

endmodule

FILE: hdl/sphere_circle_point_generator.sv
// Top level: configuration registers, divider and rotation chains, scaling and box test.
`timescale 1ns / 1ps
// Accepts one point index per clock while the output is not stalled and returns one point per index in order.
// The chain has one input stage, 33 divider cells (one quotient bit
// each), two preparation stages, 17 cells that each do one square-root step
// and, all but the last, one CORDIC rotation, three scaling stages and the output register.
// The whole chain advances whenever the output register is empty or taken,
// so a stalled output holds every stage. Configuration must be written
// while no item is in flight.
module sphere_circle_point_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // point_index
  output logic        out_tvalid,
  input  logic        out_tready,
  // echo_index[15:0], coord_x[35:16], coord_y[55:36], coord_z[75:56],
  // inside_box[76], zero fill
  output logic [79:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [59:0] cfg_wdata
);

  localparam int NSTG = 1 + scpg_pkg::DIV_N + 2 + scpg_pkg::ROT_N + 3;

  logic        mode_r;
  logic [15:0] count_r;
  logic [59:0] centre_r, blo_r, bhi_r;
  logic [18:0] rmaj_r, rmin_r;
  logic [15:0] n_eff;
  logic        adv, in_fire;
  logic [NSTG-1:0] vld_r;
  logic        out_tvalid_r;
  logic [79:0] out_tdata_r;

  scpg_pkg::pipe_t s_in_r, s_in_nxt;
  scpg_pkg::pipe_t div_q [scpg_pkg::DIV_N+1];
  scpg_pkg::pipe_t p1_r, p1_nxt, p2_r, p2_nxt;
  scpg_pkg::pipe_t rot_q [scpg_pkg::ROT_N+1];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
      count_r <= 16'd1;
      centre_r <= '0;
      rmaj_r <= '0;
      rmin_r <= '0;
      blo_r <= '0;
      bhi_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        scpg_pkg::REG_MODE:   mode_r   <= cfg_wdata[0];
        scpg_pkg::REG_COUNT:  count_r  <= cfg_wdata[15:0];
        scpg_pkg::REG_CENTRE: centre_r <= cfg_wdata;
        scpg_pkg::REG_MAJOR:  rmaj_r   <= cfg_wdata[18:0];
        scpg_pkg::REG_MINOR:  rmin_r   <= cfg_wdata[18:0];
        scpg_pkg::REG_BOX_LO: blo_r    <= cfg_wdata;
        scpg_pkg::REG_BOX_HI: bhi_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign n_eff   = (count_r == 16'd0) ? 16'd1 : count_r;
  assign adv     = !out_tvalid_r || out_tready;
  assign in_tready = adv;
  assign in_fire = in_tvalid && adv;

  // Valid bits follow the payload down the chain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_fire};
      out_tvalid_r <= vld_r[NSTG-1];
    end
  end

  // Input stage: golden-angle turn and the dividend.
  always_comb begin
    logic [47:0] gprod;
    gprod = in_tdata * scpg_pkg::GOLDEN_TURN;
    s_in_nxt = '0;
    s_in_nxt.idx  = in_tdata;
    s_in_nxt.turn = gprod[31:0];
    s_in_nxt.dq   = mode_r ? {in_tdata, 17'd0} : {1'b0, in_tdata, 16'd0};
  end

  always_ff @(posedge clk) begin
    if (adv) s_in_r <= s_in_nxt;
  end

  assign div_q[0] = s_in_r;

  genvar g;
  generate
    for (g = 0; g < scpg_pkg::DIV_N; g++) begin : g_div
      scpg_div_cell u_div (
        .clk(clk), .en(adv), .divisor(n_eff), .d_in(div_q[g]), .d_out(div_q[g+1])
      );
    end
  endgenerate

  // Sphere height, angle fold and CORDIC start.
  always_comb begin
    logic [32:0] q;
    logic [31:0] turn, tp, tf;
    q = div_q[scpg_pkg::DIV_N].dq;
    p1_nxt = div_q[scpg_pkg::DIV_N];
    if (q > 33'd131072) begin
      p1_nxt.zq = -18'sd65536;
    end else begin
      p1_nxt.zq = 18'(19'sd65536 - $signed({1'b0, q[17:0]}));
    end
    turn = mode_r ? div_q[scpg_pkg::DIV_N].turn : {q[15:0], 16'h0};
    tp = turn + 32'h4000_0000;
    tf = tp[31] ? turn + 32'h8000_0000 : turn;
    p1_nxt.flip = tp[31];
    p1_nxt.cx = scpg_pkg::CORDIC_START;
    p1_nxt.cy = '0;
    p1_nxt.cz = {{2{tf[31]}}, tf};
  end

  always_ff @(posedge clk) begin
    if (adv) p1_r <= p1_nxt;
  end

  // Radicand for the sphere radius.
  always_comb begin
    logic signed [35:0] zsq;
    zsq = p1_r.zq * p1_r.zq;
    p2_nxt = p1_r;
    p2_nxt.sd = 33'(34'h1_0000_0000 - zsq[33:0]);
    p2_nxt.sres = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) p2_r <= p2_nxt;
  end

  assign rot_q[0] = p2_r;

  generate
    for (g = 0; g < scpg_pkg::ROT_N; g++) begin : g_rot
      scpg_rot_cell u_rot (
        .clk(clk), .en(adv), .step(5'(g)), .d_in(rot_q[g]), .d_out(rot_q[g+1])
      );
    end
  endgenerate

  // Unit vector: clamp, unfold and scale by the radius in sphere mode.
  scpg_pkg::pipe_t    fin;
  logic signed [17:0] cc, ss, rr;
  logic signed [35:0] pc, ps;
  logic signed [17:0] ux_r, uy_r, zq1_r;
  logic [15:0]        idx1_r;

  assign fin = rot_q[scpg_pkg::ROT_N];

  always_comb begin
    logic signed [17:0] cl, sl;
    cl = (fin.cx > 20'sd65536) ? 18'sd65536 :
         (fin.cx < -20'sd65536) ? -18'sd65536 : 18'(fin.cx);
    sl = (fin.cy > 20'sd65536) ? 18'sd65536 :
         (fin.cy < -20'sd65536) ? -18'sd65536 : 18'(fin.cy);
    cc = fin.flip ? -cl : cl;
    ss = fin.flip ? -sl : sl;
    rr = $signed({1'b0, fin.sres[16:0]});
    pc = rr * cc;
    ps = rr * ss;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ux_r   <= mode_r ? 18'(pc >>> 16) : cc;
      uy_r   <= mode_r ? 18'(ps >>> 16) : ss;
      zq1_r  <= fin.zq;
      idx1_r <= fin.idx;
    end
  end

  // Offsets from the centre.
  logic signed [20:0] ox_r, oy_r, oz_r;
  logic [15:0]        idx2_r;

  always_ff @(posedge clk) begin
    logic signed [37:0] mx, my, mz;
    mx = $signed({1'b0, rmaj_r}) * ux_r;
    my = $signed({1'b0, (mode_r ? rmaj_r : rmin_r)}) * uy_r;
    mz = $signed({1'b0, rmaj_r}) * zq1_r;
    if (adv) begin
      ox_r <= 21'(mx >>> 16);
      oy_r <= 21'(my >>> 16);
      oz_r <= mode_r ? 21'(mz >>> 16) : 21'sd0;
      idx2_r <= idx1_r;
    end
  end

  // Saturated coordinates.
  function automatic logic signed [19:0] sat_add(input logic signed [19:0] c,
                                                 input logic signed [20:0] o);
    logic signed [21:0] s;
    s = 22'(c) + 22'(o);
    if (s > 22'sd524287) return 20'sd524287;
    if (s < -22'sd524288) return -20'sd524288;
    return s[19:0];
  endfunction

  logic signed [19:0] px_r, py_r, pz_r;
  logic [15:0]        idx3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r <= sat_add($signed(centre_r[19:0]), ox_r);
      py_r <= sat_add($signed(centre_r[39:20]), oy_r);
      pz_r <= sat_add($signed(centre_r[59:40]), oz_r);
      idx3_r <= idx2_r;
    end
  end

  // Box test and output register.
  logic in_box;
  always_comb begin
    in_box = (px_r >= $signed(blo_r[19:0]))  && (px_r < $signed(bhi_r[19:0])) &&
             (py_r >= $signed(blo_r[39:20])) && (py_r < $signed(bhi_r[39:20])) &&
             (pz_r >= $signed(blo_r[59:40])) && (pz_r < $signed(bhi_r[59:40]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= {3'b000, in_box, pz_r, py_r, px_r, idx3_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

FILE: hdl/scpg_checker.sv
// Port-level checks for the point generator, bound to the top level.
`timescale 1ns / 1ps
module scpg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata
);

  // A result request holds until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result request dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result payload changed while stalled");

  // With the output empty the chain must take input.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // A stalled output must refuse new input.
  a_stall_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while output stalled");

endmodule

bind sphere_circle_point_generator scpg_checker u_scpg_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
